// ===== sv/pl0_register_stack_machine_core_macros.svh =====
// assertion macros for the pl0 register machine core
`ifndef PL0_REGISTER_STACK_MACHINE_CORE_MACROS_SVH
`define PL0_REGISTER_STACK_MACHINE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PL0_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PL0_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PL0_ASSERT_IMP(lbl, ante, cons)
`define PL0_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/pl0rsm_pkg.sv =====
package pl0rsm_pkg;

  localparam int WORD_W      = 32;
  localparam int STACK_DEPTH = 2048;
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int CODE_DEPTH  = 512;
  localparam int CAW         = $clog2(CODE_DEPTH);
  localparam int REG_COUNT   = 16;
  localparam int RAW         = $clog2(REG_COUNT);

  // opcodes
  localparam logic [4:0] OP_LIT = 5'd1;
  localparam logic [4:0] OP_RTN = 5'd2;
  localparam logic [4:0] OP_LOD = 5'd3;
  localparam logic [4:0] OP_STO = 5'd4;
  localparam logic [4:0] OP_CAL = 5'd5;
  localparam logic [4:0] OP_INC = 5'd6;
  localparam logic [4:0] OP_JMP = 5'd7;
  localparam logic [4:0] OP_JPC = 5'd8;
  localparam logic [4:0] OP_OUT = 5'd9;
  localparam logic [4:0] OP_RED = 5'd10;
  localparam logic [4:0] OP_NEG = 5'd11;
  localparam logic [4:0] OP_ADD = 5'd12;
  localparam logic [4:0] OP_SUB = 5'd13;
  localparam logic [4:0] OP_MUL = 5'd14;
  localparam logic [4:0] OP_DIV = 5'd15;
  localparam logic [4:0] OP_ODD = 5'd16;
  localparam logic [4:0] OP_MOD = 5'd17;
  localparam logic [4:0] OP_EQL = 5'd18;
  localparam logic [4:0] OP_NEQ = 5'd19;
  localparam logic [4:0] OP_LSS = 5'd20;
  localparam logic [4:0] OP_LEQ = 5'd21;
  localparam logic [4:0] OP_GTR = 5'd22;
  localparam logic [4:0] OP_GEQ = 5'd23;

  // status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;
  localparam logic [1:0] ST_DIVZ = 2'd3;

  // register file read select
  localparam logic [1:0] RS_A = 2'd0;
  localparam logic [1:0] RS_B = 2'd1;
  localparam logic [1:0] RS_R = 2'd2;

  // stack address select
  localparam logic [3:0] AS_BM  = 4'd0;
  localparam logic [3:0] AS_SP1 = 4'd1;
  localparam logic [3:0] AS_SP2 = 4'd2;
  localparam logic [3:0] AS_SP3 = 4'd3;
  localparam logic [3:0] AS_SP4 = 4'd4;
  localparam logic [3:0] AS_BP2 = 4'd5;
  localparam logic [3:0] AS_BP3 = 4'd6;
  localparam logic [3:0] AS_B1  = 4'd7;
  localparam logic [3:0] AS_CLR = 4'd8;

  // result register source
  localparam logic [1:0] RES_ALU = 2'd0;
  localparam logic [1:0] RES_STK = 2'd1;
  localparam logic [1:0] RES_DIV = 2'd2;

  typedef struct packed {
    logic       clr;
    logic       latch;
    logic [1:0] rf_sel;
    logic       cap_a;
    logic       cap_b;
    logic       cap_r;
    logic       walk_init;
    logic       walk_cap;
    logic       st_we;
    logic [3:0] asel;
    logic       res_ld;
    logic [1:0] res_sel;
    logic       tmp_ld;
    logic       div_start;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic [4:0] op;
    logic       halted;
    logic       vb_zero;
    logic       lv_zero;
    logic       div_done;
    logic       clr_last;
    logic       out_free;
  } sts_t;

  // opcodes that write register R
  function automatic logic writes_reg(input logic [4:0] op);
    case (op)
      OP_LIT, OP_LOD, OP_RED, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_ODD,
      OP_MOD, OP_EQL, OP_NEQ, OP_LSS, OP_LEQ, OP_GTR, OP_GEQ: writes_reg = 1'b1;
      default: writes_reg = 1'b0;
    endcase
  endfunction

endpackage

// ===== sv/pl0rsm_ram.sv =====
module pl0rsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/pl0rsm_div.sv =====
module pl0rsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       want_rem,
  input  logic [pl0rsm_pkg::WORD_W-1:0] dividend,
  input  logic [pl0rsm_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [pl0rsm_pkg::WORD_W-1:0] result
);

  localparam int W  = pl0rsm_pkg::WORD_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  mb_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          na_r, nb_r, rem_sel_r;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, mb_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend[W-1] ? (W'(0) - dividend) : dividend;
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[W-2:0], !trial[W]};
      rem_nxt = trial[W] ? shifted[W-1:0] : trial[W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      mb_r      <= divisor[W-1] ? (W'(0) - divisor) : divisor;
      na_r      <= dividend[W-1];
      nb_r      <= divisor[W-1];
      rem_sel_r <= want_rem;
    end
  end

  // sign fix: quotient toward zero, remainder follows dividend
  always_comb begin
    if (rem_sel_r) begin
      result = na_r ? (W'(0) - rem_r) : rem_r;
    end else begin
      result = (na_r != nb_r) ? (W'(0) - quo_r) : quo_r;
    end
  end

  assign done = done_r;

endmodule

// ===== sv/pl0rsm_dp.sv =====
module pl0rsm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pl0rsm_pkg::cmd_t     cmd,
  output pl0rsm_pkg::sts_t     sts,
  input  logic [55:0]          in_tdata,
  input  logic [4:0]           in_tuser,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [71:0]          out_tdata,
  output logic                 out_tuser
);

  localparam int W   = pl0rsm_pkg::WORD_W;
  localparam int SAW = pl0rsm_pkg::SAW;
  localparam int CAW = pl0rsm_pkg::CAW;
  localparam int RAW = pl0rsm_pkg::RAW;

  // latched instruction
  logic [4:0]         op_r;
  logic [3:0]         rix_r;
  logic [3:0]         lvl_r;
  logic signed [15:0] m_r;
  logic [31:0]        rdv_r;

  // machine state
  logic [CAW-1:0] pc_r, pc_nxt;
  logic [SAW-1:0] bp_r, bp_nxt;
  logic [SAW-1:0] sp_r, sp_nxt;
  logic           halted_r, halted_nxt;
  logic [1:0]     stat_nxt;

  // work registers
  logic [W-1:0]   va_r, vb_r, vr_r, res_r, tmp_r, alu;
  logic [SAW-1:0] b_r;
  logic [3:0]     lcnt_r;
  logic [SAW-1:0] clr_r;

  // memories
  logic [RAW-1:0] rf_addr;
  logic           rf_we;
  logic [W-1:0]   rf_rdata, rf_val;
  logic [pl0rsm_pkg::REG_COUNT-1:0] rf_vld_r;
  logic           rd_vld_r;
  logic [SAW-1:0] st_addr;
  logic [W-1:0]   st_wdata, st_rdata;

  logic           div_done;
  logic [W-1:0]   div_res;

  // output register
  logic           ovld_r;
  logic [71:0]    odata_r;
  logic           oflag_r;

  // instruction capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_tuser;
      rix_r <= in_tdata[3:0];
      lvl_r <= in_tdata[7:4];
      m_r   <= in_tdata[23:8];
      rdv_r <= in_tdata[55:24];
    end
  end

  // register file, invalid entries read as zero
  always_comb begin
    rf_we = cmd.commit && !halted_r && pl0rsm_pkg::writes_reg(op_r);
    if (rf_we) begin
      rf_addr = rix_r[RAW-1:0];
    end else begin
      case (cmd.rf_sel)
        pl0rsm_pkg::RS_A: rf_addr = lvl_r[RAW-1:0];
        pl0rsm_pkg::RS_B: rf_addr = m_r[RAW-1:0];
        default:          rf_addr = rix_r[RAW-1:0];
      endcase
    end
  end

  pl0rsm_ram #(.WIDTH(W), .DEPTH(pl0rsm_pkg::REG_COUNT)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .addr  (rf_addr),
    .wdata (res_r),
    .rdata (rf_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rf_vld_r[rf_addr];
      if (rf_we) begin
        rf_vld_r[rf_addr] <= 1'b1;
      end
    end
  end

  assign rf_val = rd_vld_r ? rf_rdata : '0;

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.cap_a) va_r <= rf_val;
    if (cmd.cap_b) vb_r <= rf_val;
    if (cmd.cap_r) vr_r <= rf_val;
  end

  // stack address and write data
  always_comb begin
    case (cmd.asel)
      pl0rsm_pkg::AS_BM:  st_addr = b_r + SAW'(m_r);
      pl0rsm_pkg::AS_SP1: st_addr = sp_r + SAW'(1);
      pl0rsm_pkg::AS_SP2: st_addr = sp_r + SAW'(2);
      pl0rsm_pkg::AS_SP3: st_addr = sp_r + SAW'(3);
      pl0rsm_pkg::AS_SP4: st_addr = sp_r + SAW'(4);
      pl0rsm_pkg::AS_BP2: st_addr = bp_r + SAW'(2);
      pl0rsm_pkg::AS_BP3: st_addr = bp_r + SAW'(3);
      pl0rsm_pkg::AS_B1:  st_addr = b_r + SAW'(1);
      default:            st_addr = clr_r;
    endcase
    case (cmd.asel)
      pl0rsm_pkg::AS_BM:  st_wdata = vr_r;
      pl0rsm_pkg::AS_SP2: st_wdata = W'(b_r);
      pl0rsm_pkg::AS_SP3: st_wdata = W'(bp_r);
      pl0rsm_pkg::AS_SP4: st_wdata = W'(pc_r);
      default:            st_wdata = '0;
    endcase
  end

  pl0rsm_ram #(.WIDTH(W), .DEPTH(pl0rsm_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (cmd.st_we),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr) begin
      clr_r <= clr_r + SAW'(1);
    end
  end

  // static link walk
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      b_r    <= bp_r;
      lcnt_r <= lvl_r;
    end else if (cmd.walk_cap) begin
      b_r    <= st_rdata[SAW-1:0];
      lcnt_r <= lcnt_r - 4'd1;
    end
  end

  // divider
  pl0rsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .want_rem (op_r == pl0rsm_pkg::OP_MOD),
    .dividend (va_r),
    .divisor  (vb_r),
    .done     (div_done),
    .result   (div_res)
  );

  // combinational alu
  always_comb begin
    case (op_r)
      pl0rsm_pkg::OP_LIT: alu = W'(m_r);
      pl0rsm_pkg::OP_RED: alu = W'($signed(rdv_r));
      pl0rsm_pkg::OP_NEG: alu = W'(0) - va_r;
      pl0rsm_pkg::OP_ADD: alu = va_r + vb_r;
      pl0rsm_pkg::OP_SUB: alu = va_r - vb_r;
      pl0rsm_pkg::OP_MUL: alu = va_r * vb_r;
      pl0rsm_pkg::OP_ODD: alu = !vr_r[0] ? '0 : (vr_r[W-1] ? '1 : W'(1));
      pl0rsm_pkg::OP_EQL: alu = W'(va_r == vb_r);
      pl0rsm_pkg::OP_NEQ: alu = W'(va_r != vb_r);
      pl0rsm_pkg::OP_LSS: alu = W'($signed(va_r) < $signed(vb_r));
      pl0rsm_pkg::OP_LEQ: alu = W'(!($signed(vb_r) < $signed(va_r)));
      pl0rsm_pkg::OP_GTR: alu = W'($signed(vb_r) < $signed(va_r));
      pl0rsm_pkg::OP_GEQ: alu = W'(!($signed(va_r) < $signed(vb_r)));
      default:            alu = '0;
    endcase
  end

  // result and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      case (cmd.res_sel)
        pl0rsm_pkg::RES_STK: res_r <= st_rdata;
        pl0rsm_pkg::RES_DIV: res_r <= div_res;
        default:             res_r <= alu;
      endcase
    end
    if (cmd.tmp_ld) begin
      tmp_r <= st_rdata;
    end
  end

  // pointer updates at commit
  always_comb begin
    pc_nxt     = pc_r;
    bp_nxt     = bp_r;
    sp_nxt     = sp_r;
    stat_nxt   = pl0rsm_pkg::ST_RUN;
    halted_nxt = halted_r;
    if (halted_r) begin
      stat_nxt = pl0rsm_pkg::ST_HALT;
    end else begin
      case (op_r)
        pl0rsm_pkg::OP_RTN: begin
          sp_nxt = bp_r - SAW'(1);
          pc_nxt = tmp_r[CAW-1:0];
          bp_nxt = res_r[SAW-1:0];
        end
        pl0rsm_pkg::OP_CAL: begin
          bp_nxt = sp_r + SAW'(1);
          pc_nxt = m_r[CAW-1:0];
        end
        pl0rsm_pkg::OP_INC: sp_nxt = sp_r + SAW'(m_r);
        pl0rsm_pkg::OP_JMP: pc_nxt = m_r[CAW-1:0];
        pl0rsm_pkg::OP_JPC: begin
          if (vr_r == '0) begin
            pc_nxt = m_r[CAW-1:0];
          end
        end
        pl0rsm_pkg::OP_DIV, pl0rsm_pkg::OP_MOD: begin
          if (vb_r == '0) begin
            stat_nxt = pl0rsm_pkg::ST_DIVZ;
          end
        end
        pl0rsm_pkg::OP_LIT, pl0rsm_pkg::OP_LOD, pl0rsm_pkg::OP_STO,
        pl0rsm_pkg::OP_OUT, pl0rsm_pkg::OP_RED, pl0rsm_pkg::OP_NEG,
        pl0rsm_pkg::OP_ADD, pl0rsm_pkg::OP_SUB, pl0rsm_pkg::OP_MUL,
        pl0rsm_pkg::OP_ODD, pl0rsm_pkg::OP_EQL, pl0rsm_pkg::OP_NEQ,
        pl0rsm_pkg::OP_LSS, pl0rsm_pkg::OP_LEQ, pl0rsm_pkg::OP_GTR,
        pl0rsm_pkg::OP_GEQ: stat_nxt = pl0rsm_pkg::ST_RUN;
        default: stat_nxt = pl0rsm_pkg::ST_BAD;
      endcase
      if (stat_nxt == pl0rsm_pkg::ST_RUN && bp_nxt == '0) begin
        stat_nxt = pl0rsm_pkg::ST_HALT;
      end
      if (stat_nxt != pl0rsm_pkg::ST_RUN) begin
        halted_nxt = 1'b1;
      end
    end
  end

  // machine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      bp_r     <= SAW'(1);
      sp_r     <= '0;
      halted_r <= 1'b0;
    end else if (cmd.latch) begin
      if (!halted_r) begin
        pc_r <= pc_r + CAW'(1);
      end
    end else if (cmd.commit) begin
      pc_r     <= pc_nxt;
      bp_r     <= bp_nxt;
      sp_r     <= sp_nxt;
      halted_r <= halted_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.commit) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      oflag_r <= !halted_r && op_r == pl0rsm_pkg::OP_OUT;
      odata_r <= {7'd0, stat_nxt,
                  (!halted_r && op_r == pl0rsm_pkg::OP_OUT) ? vr_r[31:0] : 32'd0,
                  11'(sp_nxt), 11'(bp_nxt), 9'(pc_nxt)};
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = oflag_r;

  // status to controller
  always_comb begin
    sts.op       = op_r;
    sts.halted   = halted_r;
    sts.vb_zero  = (vb_r == '0);
    sts.lv_zero  = (lcnt_r == 4'd0);
    sts.div_done = div_done;
    sts.clr_last = (clr_r == SAW'(pl0rsm_pkg::STACK_DEPTH - 1));
    sts.out_free = !ovld_r || out_tready;
  end

endmodule

// ===== sv/pl0rsm_ctrl.sv =====
module pl0rsm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  pl0rsm_pkg::sts_t sts,
  output pl0rsm_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_RA   = 5'd2;
  localparam logic [4:0] S_RB   = 5'd3;
  localparam logic [4:0] S_RR   = 5'd4;
  localparam logic [4:0] S_RX   = 5'd5;
  localparam logic [4:0] S_EXE  = 5'd6;
  localparam logic [4:0] S_WALK = 5'd7;
  localparam logic [4:0] S_WCAP = 5'd8;
  localparam logic [4:0] S_LD1  = 5'd9;
  localparam logic [4:0] S_LD2  = 5'd10;
  localparam logic [4:0] S_CW1  = 5'd11;
  localparam logic [4:0] S_CW2  = 5'd12;
  localparam logic [4:0] S_CW3  = 5'd13;
  localparam logic [4:0] S_CW4  = 5'd14;
  localparam logic [4:0] S_RT1  = 5'd15;
  localparam logic [4:0] S_RT2  = 5'd16;
  localparam logic [4:0] S_RT3  = 5'd17;
  localparam logic [4:0] S_DIVS = 5'd18;
  localparam logic [4:0] S_DIVW = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // sequencing and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.asel  = pl0rsm_pkg::AS_CLR;
    cmd.rf_sel = pl0rsm_pkg::RS_A;
    case (state_r)
      S_CLR: begin
        cmd.clr   = 1'b1;
        cmd.st_we = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = sts.halted ? S_FIN : S_RA;
        end
      end
      S_RA: begin
        cmd.rf_sel = pl0rsm_pkg::RS_A;
        state_nxt  = S_RB;
      end
      S_RB: begin
        cmd.rf_sel = pl0rsm_pkg::RS_B;
        cmd.cap_a  = 1'b1;
        state_nxt  = S_RR;
      end
      S_RR: begin
        cmd.rf_sel = pl0rsm_pkg::RS_R;
        cmd.cap_b  = 1'b1;
        state_nxt  = S_RX;
      end
      S_RX: begin
        cmd.cap_r     = 1'b1;
        cmd.walk_init = 1'b1;
        case (sts.op)
          pl0rsm_pkg::OP_LOD,
          pl0rsm_pkg::OP_STO: state_nxt = S_WALK;
          pl0rsm_pkg::OP_CAL: state_nxt = S_CW1;
          pl0rsm_pkg::OP_RTN: state_nxt = S_RT1;
          pl0rsm_pkg::OP_DIV,
          pl0rsm_pkg::OP_MOD: state_nxt = sts.vb_zero ? S_EXE : S_DIVS;
          default:            state_nxt = S_EXE;
        endcase
      end
      S_EXE: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = pl0rsm_pkg::RES_ALU;
        state_nxt   = S_FIN;
      end
      S_WALK: begin
        if (!sts.lv_zero) begin
          cmd.asel  = pl0rsm_pkg::AS_B1;
          state_nxt = S_WCAP;
        end else begin
          case (sts.op)
            pl0rsm_pkg::OP_LOD: state_nxt = S_LD1;
            pl0rsm_pkg::OP_STO: begin
              cmd.asel  = pl0rsm_pkg::AS_BM;
              cmd.st_we = 1'b1;
              state_nxt = S_FIN;
            end
            default: state_nxt = S_CW2;
          endcase
        end
      end
      S_WCAP: begin
        cmd.walk_cap = 1'b1;
        state_nxt    = S_WALK;
      end
      S_LD1: begin
        cmd.asel  = pl0rsm_pkg::AS_BM;
        state_nxt = S_LD2;
      end
      S_LD2: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = pl0rsm_pkg::RES_STK;
        state_nxt   = S_FIN;
      end
      // call frame: clear the first slot, walk the links, then fill the rest
      S_CW1: begin
        cmd.asel  = pl0rsm_pkg::AS_SP1;
        cmd.st_we = 1'b1;
        state_nxt = S_WALK;
      end
      S_CW2: begin
        cmd.asel  = pl0rsm_pkg::AS_SP2;
        cmd.st_we = 1'b1;
        state_nxt = S_CW3;
      end
      S_CW3: begin
        cmd.asel  = pl0rsm_pkg::AS_SP3;
        cmd.st_we = 1'b1;
        state_nxt = S_CW4;
      end
      S_CW4: begin
        cmd.asel  = pl0rsm_pkg::AS_SP4;
        cmd.st_we = 1'b1;
        state_nxt = S_FIN;
      end
      // return: fetch saved pc then saved bp
      S_RT1: begin
        cmd.asel  = pl0rsm_pkg::AS_BP3;
        state_nxt = S_RT2;
      end
      S_RT2: begin
        cmd.asel   = pl0rsm_pkg::AS_BP2;
        cmd.tmp_ld = 1'b1;
        state_nxt  = S_RT3;
      end
      S_RT3: begin
        cmd.res_ld  = 1'b1;
        cmd.res_sel = pl0rsm_pkg::RES_STK;
        state_nxt   = S_FIN;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.res_ld  = 1'b1;
          cmd.res_sel = pl0rsm_pkg::RES_DIV;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/pl0_register_stack_machine_core.sv =====
// channel  dir  tdata                                         tuser
// in_      in   reg_index, level_or_src_a, operand_m,         opcode
//               read_value (56 bits)
// out_     out  next_pc, base_now, top_now, out_value,        out_valid
//               status (72 bits, zero filled)
//
// one instruction at a time: register and jump ops read, execute and commit;
// lod/sto/cal add a static link read per level, cal also writes its frame,
// div/mod use the divider, one quotient bit per cycle; a halted step only commits.
// the single-port stack memory and register file set the step count.
// after reset a pass over all 2048 stack entries clears the stack before the first beat.
// a finished beat waits in the output register; the next beat is taken meanwhile.
`include "pl0_register_stack_machine_core_macros.svh"

module pl0_register_stack_machine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // reg_index, level_or_src_a, operand_m, read_value
  input  logic [4:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // next_pc, base_now, top_now, out_value, status
  output logic        out_tuser   // out_valid
);

  pl0rsm_pkg::cmd_t cmd;
  pl0rsm_pkg::sts_t sts;

  pl0rsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pl0rsm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // checks
  `PL0_ASSERT_IMP(a_commit_free, cmd.commit, sts.out_free)
  `PL0_ASSERT_NXT(a_commit_beat, cmd.commit, out_tvalid)
  `PL0_ASSERT_IMP(a_latch_noclr, cmd.latch, !cmd.clr && !cmd.st_we)
  `PL0_ASSERT_IMP(a_div_nonzero, cmd.div_start, !sts.vb_zero && !sts.halted)

endmodule
